@@ hw/rtl/falu_pkg.sv @@
// ----------------------------------------------------------------------------
// falu_pkg
// types and constants shared by the fixed-point alu pipeline
// ----------------------------------------------------------------------------
package falu_pkg;

  // number of quotient bits resolved by the divider chain
  localparam int unsigned QBits = 34;

  typedef enum logic [3:0] {
    ModeAdd     = 4'd0,
    ModeSub     = 4'd1,
    ModeMul     = 4'd2,
    ModeDiv     = 4'd3,
    ModeMin     = 4'd4,
    ModeMax     = 4'd5,
    ModeCmp     = 4'd6,
    ModeInc     = 4'd7,
    ModeDec     = 4'd8,
    ModeToInt   = 4'd9,
    ModeFromInt = 4'd10
  } mode_e;

  typedef struct packed {
    logic [3:0]         mode;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } req_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               a_less;
    logic               a_equal;
    logic               a_greater;
    logic               divide_by_zero;
    logic               saturated;
  } rsp_t;

  // payload carried down the chain of divider cells
  typedef struct packed {
    logic [3:0]         mode;
    logic [31:0]        res;
    logic               less;
    logic               equal;
    logic               greater;
    logic               dz;
    logic signed [63:0] prod;
    logic               ovf;
    logic               neg;
    logic [31:0]        rem;
    logic [31:0]        den;
    logic [QBits-1:0]   nbits;
    logic [QBits-1:0]   quo;
  } stage_t;

endpackage

@@ hw/rtl/fixed_point_alu.sv @@
// ----------------------------------------------------------------------------
// fixed_point_alu
// signed fixed-point alu on 32-bit words, one request per cycle
// ----------------------------------------------------------------------------
// A request carries a mode and two signed 32-bit words with FRAC_BITS fraction
// bits; each gives one response with the result and compare flags. Add, sub,
// inc, dec and from_int wrap; mul and div round to nearest (ties away from
// zero) and saturate; divide by zero returns zero and raises its flag. The
// block takes one request every cycle while it advances. A request passes the
// setup register, 34 divider cells and the output register in that order; the
// restoring division cells each resolve one quotient bit. The whole pipeline
// advances whenever the output register is empty or being taken.
// ----------------------------------------------------------------------------
module fixed_point_alu #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  falu_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output falu_pkg::rsp_t out_rsp_o
);

  // pipeline enable, shared by every stage
  logic en;

  // chain taps: entry i feeds cell i
  logic             valid_s [falu_pkg::QBits+1];
  falu_pkg::stage_t stage_s [falu_pkg::QBits+1];

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // setup: compare flags, simple results, product, division operands
  falu_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .req_i   (in_req_i),
    .valid_o (valid_s[0]),
    .stage_o (stage_s[0])
  );

  // chain of division cells, one quotient bit each
  for (genvar i = 0; i < falu_pkg::QBits; i++) begin : g_cell
    falu_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (valid_s[i]),
      .stage_i (stage_s[i]),
      .valid_o (valid_s[i+1]),
      .stage_o (stage_s[i+1])
    );
  end

  // rounding, saturation and output register
  falu_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (valid_s[falu_pkg::QBits]),
    .stage_i (stage_s[falu_pkg::QBits]),
    .valid_o (out_valid_o),
    .rsp_o   (out_rsp_o)
  );

`ifndef SYNTHESIS
  // exactly one compare flag per response
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot({out_rsp_o.a_less, out_rsp_o.a_equal, out_rsp_o.a_greater}))
    else $error("compare flags not one-hot");

  // divide by zero gives zero and no saturation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.divide_by_zero) |->
      (out_rsp_o.result_value == 32'sd0 && !out_rsp_o.saturated))
    else $error("divide by zero response malformed");

  // a clipped result sits at one end of the range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.saturated) |->
      (out_rsp_o.result_value == 32'sh7fff_ffff ||
       out_rsp_o.result_value == 32'sh8000_0000))
    else $error("saturated result not at range limit");

  // a stalled response stays in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_rsp_o)))
    else $error("stalled response lost");
`endif

endmodule

@@ hw/rtl/falu_front.sv @@
// ----------------------------------------------------------------------------
// falu_front
// operand decode, simple operations, multiply and divider setup
// ----------------------------------------------------------------------------
module falu_front #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  falu_pkg::req_t   req_i,
  output logic             valid_o,
  output falu_pkg::stage_t stage_o
);

  logic signed [31:0] a, b;
  logic [31:0]        mag_a, mag_b, to_int;
  logic [63:0]        n2;
  falu_pkg::stage_t   stage_d, stage_q;
  logic               valid_q;

  assign a = req_i.operand_a;
  assign b = req_i.operand_b;

  always_comb begin
    mag_a  = a[31] ? 32'd0 - a : a;
    mag_b  = b[31] ? 32'd0 - b : b;
    n2     = {32'd0, mag_a} << (FRAC_BITS + 1);
    to_int = mag_a >> FRAC_BITS;

    stage_d         = '0;
    stage_d.mode    = req_i.mode;
    stage_d.less    = a < b;
    stage_d.equal   = a == b;
    stage_d.greater = a > b;
    stage_d.dz      = (mag_b == 32'd0);
    stage_d.prod    = 64'(a) * 64'(b);
    stage_d.ovf     = {2'b00, n2[63:falu_pkg::QBits]} >= mag_b;
    stage_d.neg     = a[31] ^ b[31];
    stage_d.rem     = {2'b00, n2[63:falu_pkg::QBits]};
    stage_d.den     = mag_b;
    stage_d.nbits   = n2[falu_pkg::QBits-1:0];
    stage_d.quo     = '0;

    unique case (req_i.mode)
      falu_pkg::ModeAdd:     stage_d.res = a + b;
      falu_pkg::ModeSub:     stage_d.res = a - b;
      falu_pkg::ModeMin:     stage_d.res = (a < b) ? a : b;
      falu_pkg::ModeMax:     stage_d.res = (a > b) ? a : b;
      falu_pkg::ModeInc:     stage_d.res = a + 32'd1;
      falu_pkg::ModeDec:     stage_d.res = a - 32'd1;
      falu_pkg::ModeToInt:   stage_d.res = a[31] ? 32'd0 - to_int : to_int;
      falu_pkg::ModeFromInt: stage_d.res = a << FRAC_BITS;
      default:               stage_d.res = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

@@ hw/rtl/falu_div_cell.sv @@
// ----------------------------------------------------------------------------
// falu_div_cell
// one restoring division step, resolves one quotient bit
// ----------------------------------------------------------------------------
module falu_div_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  falu_pkg::stage_t stage_i,
  output logic             valid_o,
  output falu_pkg::stage_t stage_o
);

  logic [32:0]      shifted, diff;
  logic             qbit;
  falu_pkg::stage_t stage_d, stage_q;
  logic             valid_q;

  always_comb begin
    shifted       = {stage_i.rem, stage_i.nbits[falu_pkg::QBits-1]};
    diff          = shifted - {1'b0, stage_i.den};
    qbit          = shifted >= {1'b0, stage_i.den};
    stage_d       = stage_i;
    stage_d.rem   = qbit ? diff[31:0] : shifted[31:0];
    stage_d.nbits = {stage_i.nbits[falu_pkg::QBits-2:0], 1'b0};
    stage_d.quo   = {stage_i.quo[falu_pkg::QBits-2:0], qbit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

@@ hw/rtl/falu_back.sv @@
// ----------------------------------------------------------------------------
// falu_back
// multiply and divide rounding, saturation and the output register
// ----------------------------------------------------------------------------
module falu_back #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  falu_pkg::stage_t stage_i,
  output logic             valid_o,
  output falu_pkg::rsp_t   rsp_o
);

  // sign and magnitude to a clipped 32-bit word, bit 32 flags a clip
  function automatic logic [32:0] pack_sat(input logic neg, input logic [63:0] mag);
    logic [32:0] r;
    if (neg) begin
      if (mag > 64'h8000_0000) r = {1'b1, 32'h8000_0000};
      else                     r = {1'b0, 32'd0 - mag[31:0]};
    end else begin
      if (mag > 64'h7fff_ffff) r = {1'b1, 32'h7fff_ffff};
      else                     r = {1'b0, mag[31:0]};
    end
    return r;
  endfunction

  logic [63:0]          pmag, pround;
  logic [falu_pkg::QBits:0] qround;
  logic [32:0]          packed_w;
  falu_pkg::rsp_t       rsp_d, rsp_q;
  logic                 valid_q;

  always_comb begin
    pmag     = stage_i.prod[63] ? 64'd0 - stage_i.prod : stage_i.prod;
    pround   = (pmag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    qround   = ({1'b0, stage_i.quo} + 35'd1) >> 1;
    packed_w = '0;

    rsp_d                = '0;
    rsp_d.result_value   = stage_i.res;
    rsp_d.a_less         = stage_i.less;
    rsp_d.a_equal        = stage_i.equal;
    rsp_d.a_greater      = stage_i.greater;

    unique case (stage_i.mode)
      falu_pkg::ModeMul: begin
        packed_w           = pack_sat(stage_i.prod[63], pround);
        rsp_d.result_value = packed_w[31:0];
        rsp_d.saturated    = packed_w[32];
      end
      falu_pkg::ModeDiv: begin
        if (stage_i.dz) begin
          rsp_d.result_value   = '0;
          rsp_d.divide_by_zero = 1'b1;
        end else begin
          // overflow from setup means the quotient is far out of range
          packed_w = pack_sat(stage_i.neg,
                              stage_i.ovf ? 64'hffff_ffff_ffff_ffff : 64'(qround));
          rsp_d.result_value = packed_w[31:0];
          rsp_d.saturated    = packed_w[32];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rsp_q <= rsp_d;
    end
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

endmodule
